// ===== hdl/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

   localparam int KB_W        = 22;
   localparam int ADDR_W      = 32;
   localparam int RSP_ADDR_W  = 28;
   localparam int CNT_W       = 17;
   localparam int WORD_W      = 32;
   localparam int PAGE_SHIFT  = 12;

   localparam logic [KB_W-1:0]   KB_RESET  = 22'd262144;
   localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [RSP_ADDR_W-1:0] frame_address;
      logic                  ok;
      logic [CNT_W-1:0]      free_frames;
      logic [CNT_W-1:0]      frame_total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic sweep;
      logic sweep_rsv;
      logic init_set;
      logic scan;
      logic free_rd;
      logic free_chk;
      logic respond;
   } ctl_type;

   typedef struct packed {
      logic sweep_last;
      logic scan_hit;
      logic scan_miss;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/bitmap_frame_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Page-frame allocator, one bitmap bit per 4 KB frame kept in a single-port-read
// RAM of FRAME_COUNT/32 words. A request is taken when start is high and busy is
// low; its result is on rsp_data when rsp_valid is high, for exactly one cycle, and
// cannot be held off. A query goes straight to the response; a free reads the
// addressed word, then clears its bit if it is set; an alloc reads one bitmap word
// per cycle until a word with a clear bit shows up or limit is reached; an init
// writes one word per cycle across the RAM. After reset the RAM is swept to zero
// with busy high; csr writes are taken at any time and apply at the next init.
module bitmap_frame_allocator_top #(
   parameter int FRAME_COUNT     = 65536,
   parameter int RESERVED_FRAMES = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire bfa_pkg::req_type          req_data,
   output logic                           rsp_valid,
   output bfa_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [bfa_pkg::KB_W-1:0]  csr_data
);
   import bfa_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   bfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_data.cmd),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   bfa_dpath #(
      .FRAME_COUNT     (FRAME_COUNT),
      .RESERVED_FRAMES (RESERVED_FRAMES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

`ifndef SYNTHESIS
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobe");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_fail_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.frame_address == '0))
      else $error("nonzero frame address on failed request");
`endif

endmodule

`default_nettype wire

// ===== hdl/bfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [1:0]       cmd,
   input  wire bfa_pkg::sts_type sts,
   output bfa_pkg::ctl_type      ctl,
   output logic                  busy
);
   import bfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_INIT:  state_in = ST_INIT;
                  CMD_ALLOC: state_in = ST_SCAN;
                  CMD_FREE:  state_in = ST_FREE_RD;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_INIT: begin
            if (sts.sweep_last) state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (sts.scan_hit || sts.scan_miss) state_in = ST_RESP;
         end
         ST_FREE_RD:  state_in = ST_FREE_CHK;
         ST_FREE_CHK: state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: ctl.sweep = 1'b1;
         ST_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
         end
         ST_INIT: begin
            ctl.sweep     = 1'b1;
            ctl.sweep_rsv = 1'b1;
            ctl.init_set  = sts.sweep_last;
         end
         ST_SCAN:     ctl.scan     = 1'b1;
         ST_FREE_RD:  ctl.free_rd  = 1'b1;
         ST_FREE_CHK: ctl.free_chk = 1'b1;
         ST_RESP:     ctl.respond  = 1'b1;
         default:     ctl = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/bfa_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfa_dpath #(
   parameter int FRAME_COUNT     = 65536,
   parameter int RESERVED_FRAMES = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bfa_pkg::req_type          req,
   input  wire bfa_pkg::ctl_type          ctl,
   output bfa_pkg::sts_type               sts,
   input  wire logic                      csr_write,
   input  wire logic [bfa_pkg::KB_W-1:0]  csr_data,
   output logic                           rsp_valid,
   output bfa_pkg::rsp_type               rsp
);
   import bfa_pkg::*;

   localparam int WORD_COUNT  = (FRAME_COUNT + 31) / 32;
   localparam int IDX_W       = $clog2(WORD_COUNT);
   localparam int CIDX_W      = $clog2(WORD_COUNT + 1);
   localparam int LIM_W       = $clog2(FRAME_COUNT + 1);
   localparam int RSV_CLAMP   = (RESERVED_FRAMES > FRAME_COUNT) ? FRAME_COUNT
                                                                : RESERVED_FRAMES;
   localparam logic [CIDX_W-1:0] RSV_WORDS = CIDX_W'(RSV_CLAMP / 32);
   localparam logic [WORD_W-1:0] RSV_PART  = (32'd1 << (RSV_CLAMP % 32)) - 32'd1;
   localparam logic [CIDX_W-1:0] LAST_WORD = CIDX_W'(WORD_COUNT - 1);
   localparam logic [LIM_W-1:0]  LIM_MAX   = LIM_W'(FRAME_COUNT);
   localparam logic [LIM_W-1:0]  USED_INIT = LIM_W'(RSV_CLAMP);

   logic [WORD_W-1:0] used_bitmap_mem [WORD_COUNT];

   logic [KB_W-1:0]       kb_ff;
   logic [1:0]            cmd_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [CIDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rd_vld_ff;
   logic [WORD_W-1:0]     rdata_ff;
   logic [LIM_W-1:0]      limit_ff;
   logic [LIM_W-1:0]      used_ff;
   logic [LIM_W-1:0]      used_in;
   logic [RSP_ADDR_W-1:0] res_addr_ff;
   logic                  res_ok_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [CIDX_W-1:0]     words_v;
   logic                  scan_issue;
   logic [4:0]            zero_bit;
   logic [ADDR_W-PAGE_SHIFT-1:0] free_frame;
   logic                  free_in_range;
   logic                  free_hit;
   logic [IDX_W-1:0]      raddr;
   logic                  we;
   logic [IDX_W-1:0]      waddr;
   logic [WORD_W-1:0]     wdata;
   logic [WORD_W-1:0]     sweep_word;
   logic [20:0]           lim_raw;
   logic [LIM_W-1:0]      lim_new;
   logic [LIM_W-1:0]      free_cnt;

   assign words_v       = CIDX_W'(limit_ff >> 5);
   assign scan_issue    = ctl.scan && (idx_ff < words_v);
   assign free_frame    = addr_ff[ADDR_W-1:PAGE_SHIFT];
   assign free_in_range = {1'b0, free_frame} < 21'(FRAME_COUNT);
   assign free_hit      = free_in_range && rdata_ff[free_frame[4:0]];

   assign sts.sweep_last = (idx_ff == LAST_WORD);
   assign sts.scan_hit   = rd_vld_ff && (rdata_ff != FULL_WORD);
   assign sts.scan_miss  = !rd_vld_ff && (idx_ff >= words_v);

   always_comb begin
      zero_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!rdata_ff[b]) zero_bit = 5'(b);
      end
   end

   always_comb begin
      if (!ctl.sweep_rsv || idx_ff > RSV_WORDS) begin
         sweep_word = '0;
      end else if (idx_ff < RSV_WORDS) begin
         sweep_word = FULL_WORD;
      end else begin
         sweep_word = RSV_PART;
      end
   end

   always_comb begin
      lim_raw = {1'b0, kb_ff[KB_W-1:2]};
      if (lim_raw > 21'(FRAME_COUNT)) begin
         lim_new = LIM_MAX;
      end else begin
         lim_new = LIM_W'(lim_raw);
      end
   end

   always_comb begin
      raddr = idx_ff[IDX_W-1:0];
      if (ctl.free_rd) raddr = free_frame[IDX_W+4:5];
   end

   always_comb begin
      we    = 1'b0;
      waddr = idx_ff[IDX_W-1:0];
      wdata = sweep_word;
      if (ctl.sweep) begin
         we = 1'b1;
      end else if (ctl.scan && sts.scan_hit) begin
         we    = 1'b1;
         waddr = rd_idx_ff;
         wdata = rdata_ff | (WORD_W'(1) << zero_bit);
      end else if (ctl.free_chk && free_hit) begin
         we    = 1'b1;
         waddr = free_frame[IDX_W+4:5];
         wdata = rdata_ff & ~(WORD_W'(1) << free_frame[4:0]);
      end
   end

   always_comb begin
      used_in = used_ff;
      if (ctl.init_set) begin
         used_in = USED_INIT;
      end else if (ctl.scan && sts.scan_hit) begin
         used_in = LIM_W'(used_ff + 1'b1);
      end else if (ctl.free_chk && free_hit && used_ff != '0) begin
         used_in = LIM_W'(used_ff - 1'b1);
      end
   end

   assign free_cnt = (limit_ff > used_ff) ? LIM_W'(limit_ff - used_ff) : '0;

   always_ff @(posedge clock) begin
      if (we) used_bitmap_mem[waddr] <= wdata;
      rdata_ff <= used_bitmap_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kb_ff        <= KB_RESET;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         limit_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) kb_ff <= csr_data;
         if (ctl.load) begin
            idx_ff    <= '0;
            rd_vld_ff <= 1'b0;
         end else begin
            if (ctl.sweep || scan_issue) idx_ff <= CIDX_W'(idx_ff + 1'b1);
            rd_vld_ff <= scan_issue;
         end
         if (ctl.init_set) limit_ff <= lim_new;
         used_ff      <= used_in;
         rsp_valid_ff <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[IDX_W-1:0];
      if (ctl.load) begin
         cmd_ff      <= req.cmd;
         addr_ff     <= req.address;
         res_addr_ff <= '0;
         res_ok_ff   <= 1'b0;
      end else if (ctl.scan && sts.scan_hit) begin
         res_addr_ff <= RSP_ADDR_W'({rd_idx_ff, zero_bit, {PAGE_SHIFT{1'b0}}});
         res_ok_ff   <= 1'b1;
      end else if (ctl.free_chk && free_hit && cmd_ff == CMD_FREE) begin
         res_ok_ff <= 1'b1;
      end
      if (ctl.respond) begin
         rsp_ff.frame_address <= res_addr_ff;
         rsp_ff.ok            <= res_ok_ff;
         rsp_ff.free_frames   <= CNT_W'(free_cnt);
         rsp_ff.frame_total   <= CNT_W'(limit_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bfa_pkg::*;

   localparam int FRAMES      = 65536;
   localparam int RESERVED    = 1024;
   localparam int WORDS       = FRAMES / 32;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 38;

   // Mirror of the frame bitmap: predicts each response and holds them in order.
   class frame_bitmap_mirror;
      logic [WORD_W-1:0] bitmap [WORDS];
      int unsigned       frame_limit;
      int unsigned       used_count;
      int unsigned       size_kb;
      int unsigned       live_frames [$];
      rsp_type           due_results [$];
      int                mismatches;

      function new();
         foreach (bitmap[i]) bitmap[i] = '0;
         frame_limit = 0;
         used_count  = 0;
         size_kb     = KB_RESET;
         mismatches  = 0;
      endfunction

      function void set_size(input int unsigned kb);
         size_kb = kb;
      endfunction

      function void log_request(input req_type r);
         rsp_type     e;
         int unsigned words;
         int unsigned frame;
         int          hit;
         bit          found;
         e = '0;
         case (r.cmd)
            CMD_INIT: begin
               frame_limit = size_kb / 4;
               if (frame_limit > FRAMES) frame_limit = FRAMES;
               foreach (bitmap[i]) bitmap[i] = '0;
               for (int f = 0; f < RESERVED; f++) bitmap[f / 32][f % 32] = 1'b1;
               used_count = RESERVED;
               live_frames.delete();
            end
            CMD_ALLOC: begin
               words = frame_limit / 32;
               found = 1'b0;
               for (int i = 0; i < words && !found; i++) begin
                  if (bitmap[i] != FULL_WORD) begin
                     for (int b = 0; b < 32 && !found; b++) begin
                        if (!bitmap[i][b]) begin
                           bitmap[i][b] = 1'b1;
                           frame = i * 32 + b;
                           found = 1'b1;
                        end
                     end
                  end
               end
               if (found) begin
                  used_count++;
                  e.ok            = 1'b1;
                  e.frame_address = RSP_ADDR_W'(frame << PAGE_SHIFT);
                  live_frames.push_back(frame);
               end
            end
            CMD_FREE: begin
               frame = r.address >> PAGE_SHIFT;
               if (frame < FRAMES && bitmap[frame / 32][frame % 32]) begin
                  bitmap[frame / 32][frame % 32] = 1'b0;
                  if (used_count > 0) used_count--;
                  e.ok = 1'b1;
                  hit  = -1;
                  foreach (live_frames[k]) if (live_frames[k] == frame) hit = k;
                  if (hit >= 0) live_frames.delete(hit);
               end
            end
            default: ;
         endcase
         e.free_frames  = CNT_W'((frame_limit > used_count) ? frame_limit - used_count : 0);
         e.frame_total  = CNT_W'(frame_limit);
         due_results.push_back(e);
      endfunction

      function void check_response(input rsp_type r);
         rsp_type e;
         if (due_results.size() == 0) begin
            $error("response with no request outstanding: %p", r);
            mismatches++;
            return;
         end
         e = due_results.pop_front();
         if (r.frame_address !== e.frame_address) begin
            $error("frame_address expected %0h got %0h", e.frame_address, r.frame_address);
            mismatches++;
         end
         if (r.ok !== e.ok) begin
            $error("ok expected %0d got %0d", e.ok, r.ok);
            mismatches++;
         end
         if (r.free_frames !== e.free_frames) begin
            $error("free_frames expected %0d got %0d", e.free_frames, r.free_frames);
            mismatches++;
         end
         if (r.frame_total !== e.frame_total) begin
            $error("frame_total expected %0d got %0d", e.frame_total, r.frame_total);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   req_type           req       = '0;
   logic              rsp_valid;
   rsp_type           rsp;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [KB_W-1:0]   csr_data  = '0;

   frame_bitmap_mirror mirror;
   int                 cycle_count = 0;

   // per phase: memory size, sender idle percentage, alloc percentage
   int unsigned phase_kb    [PHASES] = '{262144, 4259, 0, 4194303, 4000, 4163, 8213};
   int          phase_idle  [PHASES] = '{0, 82, 0, 14, 82, 0, 14};
   int          phase_alloc [PHASES] = '{40, 75, 40, 45, 40, 40, 45};

   bitmap_frame_allocator_top #(
      .FRAME_COUNT     (FRAMES),
      .RESERVED_FRAMES (RESERVED)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[bitmap_frame_allocator_top] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) mirror.check_response(rsp);
   end

   function automatic req_type make_request(input logic [1:0] cmd, input logic [31:0] address);
      req_type r;
      r.cmd     = cmd;
      r.address = address;
      return r;
   endfunction

   function automatic req_type next_request(input int alloc_pct);
      req_type     r;
      int unsigned roll;
      int unsigned f;
      r.cmd     = CMD_QUERY;
      r.address = $urandom();
      roll      = $urandom_range(99);
      if (roll < alloc_pct) begin
         r.cmd = CMD_ALLOC;
      end else begin
         roll  = $urandom_range(99);
         r.cmd = CMD_FREE;
         if (roll < 50 && mirror.live_frames.size() > 0) begin
            f = mirror.live_frames[$urandom_range(mirror.live_frames.size() - 1)];
            r.address = (f << PAGE_SHIFT) | $urandom_range(4095);
         end else if (roll < 65) begin
            r.address = ($urandom_range(RESERVED - 1) << PAGE_SHIFT) | $urandom_range(4095);
         end else if (roll < 75) begin
            r.address = ($urandom_range(FRAMES - 1) << PAGE_SHIFT) | $urandom_range(4095);
         end else if (roll < 87) begin
            r.cmd = CMD_FREE;
         end else if (roll < 94) begin
            r.cmd = CMD_QUERY;
         end else begin
            r.cmd = CMD_INIT;
         end
      end
      return r;
   endfunction

   task automatic issue(input req_type r);
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      mirror.log_request(r);
   endtask

   task automatic sender_gap(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (mirror.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_size(input logic [KB_W-1:0] kb);
      csr_valid <= 1'b1;
      csr_data  <= kb;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror.set_size(kb);
   endtask

   initial begin
      mirror = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // before init: nothing to allocate, nothing to free
      issue(make_request(CMD_QUERY, 32'h0));
      issue(make_request(CMD_ALLOC, 32'hFFFF_FFFF));
      issue(make_request(CMD_FREE, 32'h0));
      issue(make_request(CMD_INIT, 32'h0));
      issue(make_request(CMD_ALLOC, 32'h0));
      issue(make_request(CMD_ALLOC, 32'h0));
      issue(make_request(CMD_FREE, 32'h0040_0FFF));
      issue(make_request(CMD_FREE, 32'h0040_0000));
      issue(make_request(CMD_ALLOC, 32'h0));
      // reserved frame can be freed and then handed out again
      issue(make_request(CMD_FREE, 32'h0));
      issue(make_request(CMD_ALLOC, 32'h0));
      // beyond the bitmap, and at its last frame
      issue(make_request(CMD_FREE, 32'hFFFF_FFFF));
      issue(make_request(CMD_FREE, 32'h1000_0000));
      issue(make_request(CMD_FREE, 32'h0FFF_FFFF));
      issue(make_request(CMD_QUERY, 32'hFFFF_FFFF));

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         write_size(KB_W'(phase_kb[ph]));
         issue(make_request(CMD_INIT, $urandom()));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sender_gap(phase_idle[ph]);
            issue(next_request(phase_alloc[ph]));
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.due_results.size() == 0) begin
         $display("[bitmap_frame_allocator_top] OK");
      end else begin
         $display("[bitmap_frame_allocator_top] ERROR");
      end
      $finish;
   end

endmodule
